FILE: hw/rtl/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg: shared types and constants of the buddy memory allocator
// Header kinds, status codes, opcodes and the block size shifter.
// ----------------------------------------------------------------------------
package bma_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [4:0]  log_t;
  typedef logic [16:0] bytes_t;

  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_FREE  = 2'd1;
  localparam kind_t KIND_ALLOC = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_BADFREE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int HEADER_BYTES  = 16;
  localparam int ARENA_LOG_MIN = 9;
  localparam int ARENA_LOG_MAX = 16;
  localparam log_t ARENA_LOG_RESET = 5'd16;

  // Field update mask of one read-modify-write on a slot entry
  typedef struct packed {
    logic set_kind;
    logic set_log;
    logic set_next;
    logic set_prev;
  } rmw_mask_t;

  // Block size in bytes for a block log (log never exceeds 16)
  function automatic bytes_t blk_bytes(input log_t lg);
    blk_bytes = bytes_t'(1) << lg;
  endfunction

endpackage

FILE: hw/rtl/bma_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_slot_ram: per-slot bookkeeping store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bma_slot_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 31
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/buddy_memory_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_memory_allocator: binary buddy allocator with 16-byte block headers
// First-fit allocate over an address-ordered circular free list with
// splitting, and free with address-ordered insert and buddy merging.
// ----------------------------------------------------------------------------
//
//  channel   signals                                     direction
//  --------  ------------------------------------------  ---------
//  request   req_valid, req_stall, opcode,               in
//            request_bytes, payload_offset_in
//  response  rsp_valid, rsp_stall, status,               out
//            payload_offset, block_bytes
//  config    cfg_write_en, cfg_write_data (arena_log2)   in
//
//  One request is handled at a time; every step of it goes through the
//  slot store (one read or one read-modify-write per step). Allocate
//  visits free blocks, splits the chosen one while its half still holds
//  the request, then unlinks it and marks it allocated. Free walks the
//  list, links the block after a block or as the new head, then merges
//  level by level. A malformed free is answered from idle. After reset
//  and after each config write a clearing pass over all 2^(log2 of
//  MAX_ARENA_BYTES - 4) slots (4096 by default) runs; requests stall.
//  The response sits in an output register; a stalled response blocks the
//  next request.
// ----------------------------------------------------------------------------
module buddy_memory_allocator
  import bma_pkg::*;
#(
  parameter int MAX_ARENA_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [15:0] request_bytes,
  input  logic [15:0] payload_offset_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] payload_offset,
  output logic [16:0] block_bytes
);

  localparam int MAX_LOG = $clog2(MAX_ARENA_BYTES);
  localparam int SW      = MAX_LOG - 4;     // slot index width
  localparam int EW      = 2 * SW + 7;      // kind, log, next, prev
  localparam int TOP_LOG = (MAX_LOG < ARENA_LOG_MAX) ? MAX_LOG : ARENA_LOG_MAX;

  // Sequencer states
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_CLR    = 6'd1;
  localparam logic [5:0] S_A_RD   = 6'd2;
  localparam logic [5:0] S_A_CHK  = 6'd3;
  localparam logic [5:0] S_SP_RD  = 6'd4;
  localparam logic [5:0] S_SP_CHK = 6'd5;
  localparam logic [5:0] S_SP_CUR = 6'd6;
  localparam logic [5:0] S_A_KIND = 6'd7;
  localparam logic [5:0] S_A_DONE = 6'd8;
  localparam logic [5:0] S_F_RD   = 6'd9;
  localparam logic [5:0] S_F_CHK  = 6'd10;
  localparam logic [5:0] S_FH_RD  = 6'd11;
  localparam logic [5:0] S_FH     = 6'd12;
  localparam logic [5:0] S_FH2    = 6'd13;
  localparam logic [5:0] S_FH3    = 6'd14;
  localparam logic [5:0] S_FH4    = 6'd15;
  localparam logic [5:0] S_W_RD   = 6'd16;
  localparam logic [5:0] S_W_CHK  = 6'd17;
  localparam logic [5:0] S_WI2    = 6'd18;
  localparam logic [5:0] S_WI3    = 6'd19;
  localparam logic [5:0] S_M_RD   = 6'd20;
  localparam logic [5:0] S_M_I    = 6'd21;
  localparam logic [5:0] S_M_B    = 6'd22;
  localparam logic [5:0] S_ML2    = 6'd23;
  localparam logic [5:0] S_ML3    = 6'd24;
  localparam logic [5:0] S_MU2    = 6'd25;
  localparam logic [5:0] S_MU3    = 6'd26;
  localparam logic [5:0] S_UL1    = 6'd27;
  localparam logic [5:0] S_UL2    = 6'd28;
  localparam logic [5:0] S_UL3    = 6'd29;
  localparam logic [5:0] S_RMW_RD = 6'd30;
  localparam logic [5:0] S_RMW_WR = 6'd31;

  logic [5:0]    state;
  logic [SW-1:0] clr_cnt;
  log_t          arena_log2;
  log_t          eff;

  logic [SW-1:0] head;       // lowest free slot
  logic [SW-1:0] cur;        // block under work (allocate c, free i)
  logic [SW-1:0] wc;         // walk cursor / old head
  logic [SW-1:0] bud;        // split half or merge buddy
  logic [SW-1:0] pp;         // unlink / insert neighbors
  logic [SW-1:0] nn;
  logic [SW-1:0] ulu;        // slot being unlinked
  logic [5:0]    ul_ret;
  logic [SW-1:0] ie_next;
  logic [SW-1:0] ie_prev;
  logic          lower;      // merge: cur is the lower buddy
  logic [16:0]   need;
  log_t          mlog;
  bytes_t        obytes;

  // Read-modify-write call registers
  logic [SW-1:0] rmw_addr;
  rmw_mask_t     rmw_mask;
  logic [SW-1:0] rmw_next;
  logic [SW-1:0] rmw_prev;
  kind_t         rmw_kind;
  log_t          rmw_log;
  logic [5:0]    rmw_ret;

  // Slot store port
  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [SW-1:0] raddr;
  logic [EW-1:0] rdata;

  kind_t         rd_kind;
  log_t          rd_log;
  logic [SW-1:0] rd_next;
  logic [SW-1:0] rd_prev;

  logic          accepted;
  logic          split_c;
  log_t          nl_c;
  logic [SW-1:0] bud_c;
  logic [SW-1:0] g_m;
  logic          side_hi;
  logic          buddy_ok;
  logic [15:0]   f_off;
  logic          f_bad;
  logic [SW-1:0] f_idx;
  logic [SW+3:0] cur_bytes;

  bma_slot_ram #(
    .ADDR_W (SW),
    .DATA_W (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_kind = rdata[EW-1 -: 2];
  assign rd_log  = rdata[EW-3 -: 5];
  assign rd_next = rdata[2*SW-1 -: SW];
  assign rd_prev = rdata[SW-1:0];

  // Clamp the arena register to the legal range
  always_comb begin
    eff = arena_log2;
    if (arena_log2 < 5'(ARENA_LOG_MIN)) begin
      eff = 5'(ARENA_LOG_MIN);
    end else if (arena_log2 > 5'(TOP_LOG)) begin
      eff = 5'(TOP_LOG);
    end
  end

  assign req_stall = (state != S_IDLE) || rsp_valid;
  assign accepted  = req_valid && !req_stall;

  // Split test on the block just read: halve while half still holds it
  assign nl_c    = rd_log - 5'd1;
  assign split_c = (rd_log > 5'd4) && (blk_bytes(nl_c) >= need);
  assign bud_c   = cur + SW'(blk_bytes(nl_c) >> 4);

  // Merge side and buddy distance at the current level
  assign cur_bytes = {cur, 4'b0000};
  assign side_hi   = |((SW+4)'(blk_bytes(mlog)) & cur_bytes);
  assign g_m       = SW'(blk_bytes(mlog) >> 4);
  assign buddy_ok  = (lower ? (ie_next == bud) : (ie_prev == bud)) &&
                     (rd_kind == KIND_FREE) && (rd_log == mlog);

  // Free request screening
  assign f_off = payload_offset_in - 16'(HEADER_BYTES);
  assign f_bad = (payload_offset_in[15:4] == 12'd0) || (payload_offset_in[3:0] != 4'd0) ||
                 ({1'b0, f_off} >= blk_bytes(eff));
  assign f_idx = SW'(f_off >> 4);

  // Slot store addressing and writes
  always_comb begin
    we    = 1'b0;
    waddr = rmw_addr;
    wdata = '0;
    raddr = cur;
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        if (clr_cnt == '0) begin
          wdata = {KIND_FREE, eff, {(2*SW){1'b0}}};
        end
      end
      S_SP_CHK: begin
        if (split_c) begin
          we    = 1'b1;
          waddr = bud_c;
          wdata = {KIND_FREE, nl_c, rd_next, cur};
        end
      end
      S_FH_RD:  raddr = head;
      S_W_RD:   raddr = wc;
      S_M_I:    raddr = bud;
      S_RMW_RD: raddr = rmw_addr;
      S_RMW_WR: begin
        we    = 1'b1;
        waddr = rmw_addr;
        wdata = {rmw_mask.set_kind ? rmw_kind : rd_kind,
                 rmw_mask.set_log  ? rmw_log  : rd_log,
                 rmw_mask.set_next ? rmw_next : rd_next,
                 rmw_mask.set_prev ? rmw_prev : rd_prev};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      head       <= '0;
      arena_log2 <= ARENA_LOG_RESET;
      rsp_valid  <= 1'b0;
    end else if (cfg_write_en) begin
      // new arena size: rebuild the store from scratch
      arena_log2 <= cfg_write_data;
      state      <= S_CLR;
      clr_cnt    <= '0;
      head       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accepted) begin
            if (opcode == OP_ALLOC) begin
              need  <= {1'b0, request_bytes} + 17'(HEADER_BYTES);
              cur   <= head;
              state <= S_A_RD;
            end else if (f_bad) begin
              rsp_valid      <= 1'b1;
              status         <= ST_BADFREE;
              payload_offset <= '0;
              block_bytes    <= '0;
            end else begin
              cur   <= f_idx;
              state <= S_F_RD;
            end
          end
        end
        // ---- allocate: first-fit walk ----
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          if (blk_bytes(rd_log) >= need) begin
            state <= S_SP_RD;
          end else if (rd_next == head) begin
            rsp_valid      <= 1'b1;
            status         <= ST_NOFIT;
            payload_offset <= '0;
            block_bytes    <= '0;
            state          <= S_IDLE;
          end else begin
            cur   <= rd_next;
            state <= S_A_RD;
          end
        end
        S_SP_RD: state <= S_SP_CHK;
        S_SP_CHK: begin
          mlog <= split_c ? nl_c : rd_log;
          if (split_c) begin
            // upper half written this cycle; fix its successor's back link
            bud      <= bud_c;
            rmw_addr <= rd_next;
            rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b0, set_prev: 1'b1};
            rmw_prev <= bud_c;
            rmw_ret  <= S_SP_CUR;
            state    <= S_RMW_RD;
          end else if ((rd_next == cur) && (cur == head)) begin
            rsp_valid      <= 1'b1;
            status         <= ST_NOFIT;
            payload_offset <= '0;
            block_bytes    <= '0;
            state          <= S_IDLE;
          end else begin
            ulu    <= cur;
            pp     <= rd_prev;
            nn     <= rd_next;
            ul_ret <= S_A_KIND;
            state  <= S_UL1;
          end
        end
        S_SP_CUR: begin
          rmw_addr <= cur;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b1, set_next: 1'b1, set_prev: 1'b0};
          rmw_next <= bud;
          rmw_log  <= mlog;
          rmw_ret  <= S_SP_RD;
          state    <= S_RMW_RD;
        end
        S_A_KIND: begin
          rmw_addr <= cur;
          rmw_mask <= '{set_kind: 1'b1, set_log: 1'b0, set_next: 1'b0, set_prev: 1'b0};
          rmw_kind <= KIND_ALLOC;
          rmw_ret  <= S_A_DONE;
          state    <= S_RMW_RD;
        end
        S_A_DONE: begin
          rsp_valid      <= 1'b1;
          status         <= ST_OK;
          payload_offset <= 16'(cur_bytes) + 16'(HEADER_BYTES);
          block_bytes    <= blk_bytes(mlog);
          state          <= S_IDLE;
        end
        // ---- free: validate and link in address order ----
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (rd_kind != KIND_ALLOC) begin
            rsp_valid      <= 1'b1;
            status         <= ST_BADFREE;
            payload_offset <= '0;
            block_bytes    <= '0;
            state          <= S_IDLE;
          end else begin
            obytes <= blk_bytes(rd_log);
            mlog   <= rd_log;
            wc     <= head;
            state  <= (cur < head) ? S_FH_RD : S_W_RD;
          end
        end
        S_FH_RD: state <= S_FH;
        S_FH: begin
          pp       <= rd_prev;
          rmw_addr <= cur;
          rmw_mask <= '{set_kind: 1'b1, set_log: 1'b0, set_next: 1'b1, set_prev: 1'b1};
          rmw_kind <= KIND_FREE;
          rmw_next <= wc;
          rmw_prev <= rd_prev;
          rmw_ret  <= S_FH2;
          state    <= S_RMW_RD;
        end
        S_FH2: begin
          rmw_addr <= pp;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b1, set_prev: 1'b0};
          rmw_next <= cur;
          rmw_ret  <= S_FH3;
          state    <= S_RMW_RD;
        end
        S_FH3: begin
          rmw_addr <= wc;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b0, set_prev: 1'b1};
          rmw_prev <= cur;
          rmw_ret  <= S_FH4;
          state    <= S_RMW_RD;
        end
        S_FH4: begin
          head  <= cur;
          state <= S_M_RD;
        end
        S_W_RD: state <= S_W_CHK;
        S_W_CHK: begin
          if ((rd_next == head) || (rd_next > cur)) begin
            nn       <= rd_next;
            rmw_addr <= cur;
            rmw_mask <= '{set_kind: 1'b1, set_log: 1'b0, set_next: 1'b1, set_prev: 1'b1};
            rmw_kind <= KIND_FREE;
            rmw_next <= rd_next;
            rmw_prev <= wc;
            rmw_ret  <= S_WI2;
            state    <= S_RMW_RD;
          end else begin
            wc    <= rd_next;
            state <= S_W_RD;
          end
        end
        S_WI2: begin
          rmw_addr <= nn;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b0, set_prev: 1'b1};
          rmw_prev <= cur;
          rmw_ret  <= S_WI3;
          state    <= S_RMW_RD;
        end
        S_WI3: begin
          rmw_addr <= wc;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b1, set_prev: 1'b0};
          rmw_next <= cur;
          rmw_ret  <= S_M_RD;
          state    <= S_RMW_RD;
        end
        // ---- free: merge with equal-sized free buddies ----
        S_M_RD: begin
          if (mlog >= eff) begin
            rsp_valid      <= 1'b1;
            status         <= ST_OK;
            payload_offset <= '0;
            block_bytes    <= obytes;
            state          <= S_IDLE;
          end else begin
            lower <= !side_hi;
            bud   <= side_hi ? (cur - g_m) : (cur + g_m);
            state <= S_M_I;
          end
        end
        S_M_I: begin
          ie_next <= rd_next;
          ie_prev <= rd_prev;
          state   <= S_M_B;
        end
        S_M_B: begin
          if (!buddy_ok) begin
            rsp_valid      <= 1'b1;
            status         <= ST_OK;
            payload_offset <= '0;
            block_bytes    <= obytes;
            state          <= S_IDLE;
          end else if (lower) begin
            ulu    <= bud;
            pp     <= rd_prev;
            nn     <= rd_next;
            ul_ret <= S_ML2;
            state  <= S_UL1;
          end else begin
            ulu    <= cur;
            pp     <= ie_prev;
            nn     <= ie_next;
            ul_ret <= S_MU2;
            state  <= S_UL1;
          end
        end
        S_ML2: begin
          rmw_addr <= bud;
          rmw_mask <= '{set_kind: 1'b1, set_log: 1'b1, set_next: 1'b0, set_prev: 1'b0};
          rmw_kind <= KIND_NONE;
          rmw_log  <= '0;
          rmw_ret  <= S_ML3;
          state    <= S_RMW_RD;
        end
        S_ML3: begin
          rmw_addr <= cur;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b1, set_next: 1'b0, set_prev: 1'b0};
          rmw_log  <= mlog + 5'd1;
          mlog     <= mlog + 5'd1;
          rmw_ret  <= S_M_RD;
          state    <= S_RMW_RD;
        end
        S_MU2: begin
          rmw_addr <= cur;
          rmw_mask <= '{set_kind: 1'b1, set_log: 1'b1, set_next: 1'b0, set_prev: 1'b0};
          rmw_kind <= KIND_NONE;
          rmw_log  <= '0;
          rmw_ret  <= S_MU3;
          state    <= S_RMW_RD;
        end
        S_MU3: begin
          rmw_addr <= bud;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b1, set_next: 1'b0, set_prev: 1'b0};
          rmw_log  <= mlog + 5'd1;
          mlog     <= mlog + 5'd1;
          cur      <= bud;
          rmw_ret  <= S_M_RD;
          state    <= S_RMW_RD;
        end
        // ---- unlink ulu: prev.next = next, next.prev = prev ----
        S_UL1: begin
          rmw_addr <= pp;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b1, set_prev: 1'b0};
          rmw_next <= nn;
          rmw_ret  <= S_UL2;
          state    <= S_RMW_RD;
        end
        S_UL2: begin
          rmw_addr <= nn;
          rmw_mask <= '{set_kind: 1'b0, set_log: 1'b0, set_next: 1'b0, set_prev: 1'b1};
          rmw_prev <= pp;
          rmw_ret  <= S_UL3;
          state    <= S_RMW_RD;
        end
        S_UL3: begin
          if (head == ulu) begin
            head <= nn;
          end
          state <= ul_ret;
        end
        // ---- shared read-modify-write of one slot entry ----
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: state <= rmw_ret;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (payload_offset == '0) && (block_bytes == '0))
    else $error("refused request carries nonzero payload");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK) || (status == ST_NOFIT) || (status == ST_BADFREE))
    else $error("undefined status code");

  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_OK) && (payload_offset != '0) |->
      (payload_offset[3:0] == 4'd0) && (block_bytes >= 17'(HEADER_BYTES)))
    else $error("granted block misaligned or too small");

  a_head_in_arena: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ({1'b0, head, 4'b0000} < (SW+5)'(blk_bytes(eff))))
    else $error("free list head outside the arena");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken while busy");

endmodule
